// ===== rtl/nnt_pkg.sv =====
// ----------------------------------------------------------------------------
// nnt_pkg: shared types and constants of the nearest neighbor table
// Holds the request and response beat formats, the request and status codes,
// and the internal records passed among the sequencer, the slot store and the
// distance unit.
// ----------------------------------------------------------------------------
`default_nettype none

package nnt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int ID_W        = 16;
  localparam int POS_W       = 16;
  localparam int SQ_W        = 2 * POS_W;
  localparam int DSQ_W       = SQ_W + 2;

  // Request codes. Code 3 is unused and does nothing.
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_NONE   = 2'd2;
  localparam logic [1:0] ST_ABSENT = 2'd3;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [ID_W-1:0]         entry_id;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic                    exclude_enable;
    logic [ID_W-1:0]         exclude_id;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             found;
    logic [ID_W-1:0]  nearest_id;
    logic [DSQ_W-1:0] nearest_distance_sq;
  } rsp_t;

  // Contents of one table slot.
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] z;
  } slot_t;

  // One slot as read back during a scan.
  typedef struct packed {
    logic             act;
    logic             last;
    logic             vld;
    logic [IDX_W-1:0] idx;
    slot_t            slot;
  } slot_rd_t;

  // Update of one slot: write contents and set valid, or clear valid.
  typedef struct packed {
    logic             set;
    logic             clr;
    logic [IDX_W-1:0] addr;
    slot_t            slot;
  } slot_wr_t;

  // Distance of one scanned slot to the query point.
  typedef struct packed {
    logic             act;
    logic             last;
    logic             cand;
    logic [ID_W-1:0]  id;
    logic [DSQ_W-1:0] dsq;
  } dist_t;

endpackage

`default_nettype wire

// ===== rtl/nnt_store.sv =====
// ----------------------------------------------------------------------------
// nnt_store: slot memory with valid bits
// A table of slot contents with one write port and one registered read port,
// and one valid flip-flop per slot that reset clears.
// ----------------------------------------------------------------------------
`default_nettype none

module nnt_store (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      rd_en_i,
  input  logic                      rd_last_i,
  input  logic [nnt_pkg::IDX_W-1:0] rd_addr_i,
  input  nnt_pkg::slot_wr_t         wr_i,
  output nnt_pkg::slot_rd_t         rd_o
);
  import nnt_pkg::*;

  slot_t                  mem_q [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] vld_q;
  logic                   act_q, last_q, rvld_q;
  logic [IDX_W-1:0]       idx_q;
  slot_t                  rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.set) begin
      mem_q[wr_i.addr] <= wr_i.slot;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      act_q  <= 1'b0;
      last_q <= 1'b0;
      rvld_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      if (wr_i.set) begin
        vld_q[wr_i.addr] <= 1'b1;
      end else if (wr_i.clr) begin
        vld_q[wr_i.addr] <= 1'b0;
      end
      act_q  <= rd_en_i;
      last_q <= rd_en_i && rd_last_i;
      rvld_q <= vld_q[rd_addr_i];
      idx_q  <= rd_addr_i;
    end
  end

  assign rd_o = '{act: act_q, last: last_q, vld: rvld_q, idx: idx_q, slot: rdata_q};

endmodule

`default_nettype wire

// ===== rtl/nnt_dist.sv =====
// ----------------------------------------------------------------------------
// nnt_dist: squared distance unit
// Two register stages: absolute coordinate differences, then their squares.
// The three squares are summed at the output for the minimum search.
// ----------------------------------------------------------------------------
`default_nettype none

module nnt_dist (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  nnt_pkg::slot_rd_t rd_i,
  input  nnt_pkg::req_t     req_i,
  output nnt_pkg::dist_t    dist_o
);
  import nnt_pkg::*;

  function automatic logic [POS_W-1:0] abs_diff(logic [POS_W-1:0] a, logic [POS_W-1:0] b);
    logic [POS_W:0] d;
    logic [POS_W:0] nd;
    d  = {a[POS_W-1], a} - {b[POS_W-1], b};
    nd = -d;
    return d[POS_W] ? nd[POS_W-1:0] : d[POS_W-1:0];
  endfunction

  logic             a_act_q, a_last_q, a_cand_q;
  logic [ID_W-1:0]  a_id_q;
  logic [POS_W-1:0] adx_q, ady_q, adz_q;
  logic             m_act_q, m_last_q, m_cand_q;
  logic [ID_W-1:0]  m_id_q;
  logic [SQ_W-1:0]  sqx_q, sqy_q, sqz_q;
  logic             cand;

  // A slot competes when it is valid and is not the excluded identifier.
  assign cand = rd_i.vld && !(req_i.exclude_enable && (rd_i.slot.id == req_i.exclude_id));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_act_q  <= 1'b0;
      a_last_q <= 1'b0;
      m_act_q  <= 1'b0;
      m_last_q <= 1'b0;
    end else begin
      a_act_q  <= rd_i.act;
      a_last_q <= rd_i.last;
      m_act_q  <= a_act_q;
      m_last_q <= a_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_cand_q <= cand;
    a_id_q   <= rd_i.slot.id;
    adx_q    <= abs_diff(rd_i.slot.x, req_i.pos_x);
    ady_q    <= abs_diff(rd_i.slot.y, req_i.pos_y);
    adz_q    <= abs_diff(rd_i.slot.z, req_i.pos_z);
    m_cand_q <= a_cand_q;
    m_id_q   <= a_id_q;
    sqx_q    <= SQ_W'(adx_q) * SQ_W'(adx_q);
    sqy_q    <= SQ_W'(ady_q) * SQ_W'(ady_q);
    sqz_q    <= SQ_W'(adz_q) * SQ_W'(adz_q);
  end

  assign dist_o = '{act:  m_act_q,
                    last: m_last_q,
                    cand: m_cand_q,
                    id:   m_id_q,
                    dsq:  DSQ_W'(sqx_q) + DSQ_W'(sqy_q) + DSQ_W'(sqz_q)};

endmodule

`default_nettype wire

// ===== rtl/nearest_neighbor_table.sv =====
// ----------------------------------------------------------------------------
// nearest_neighbor_table: brute-force 3-D nearest neighbor search
// A table of identified points with insert, remove and nearest-point query,
// all served by one sequential scan of the slot memory.
// ----------------------------------------------------------------------------
// Usage: a request beat (insert, remove or query) is taken at a rising edge
// where start_i is high and busy_o is low. busy_o then stays high until the
// response has been shown. Every request, including the unused code, gives
// exactly one response beat: done_o is high for a single cycle and rsp_o
// carries status, found flag, nearest identifier and squared distance in
// that same cycle. The receiver cannot hold the response off.
//
// Every request scans all TABLE_DEPTH slots, one slot per cycle through the
// single read port of the slot memory, and the scanned slots flow through a
// two-stage squared distance unit. done_o rises once the last scanned slot
// has come out of the distance unit. The next request can be taken only once
// the response beat has been shown, so the block serves one request at a time.
//
// Reset clears every slot valid bit, so the table is empty; slot contents are
// not cleared and are only ever used behind a set valid bit. Inserts land in
// the lowest free slot and query ties go to the lowest slot.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_neighbor_table (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  nnt_pkg::req_t req_i,
  output logic          busy_o,
  output logic          done_o,
  output nnt_pkg::rsp_t rsp_o
);
  import nnt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  req_t             req_q;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic             cnt_last;

  // Scan results: identifier match, lowest free slot, best query candidate.
  logic             match_q, match_d;
  logic [IDX_W-1:0] match_idx_q, match_idx_d;
  logic             free_q, free_d;
  logic [IDX_W-1:0] free_idx_q, free_idx_d;
  logic             have_q, have_d;
  logic [ID_W-1:0]  best_id_q, best_id_d;
  logic [DSQ_W-1:0] best_q, best_d;

  slot_rd_t         rd;
  slot_wr_t         wr;
  dist_t            dist_res;
  logic             accept;

  assign accept   = start_i && (state_q == S_IDLE);
  assign cnt_last = (cnt_q == IDX_W'(TABLE_DEPTH - 1));

  nnt_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (state_q == S_SCAN),
    .rd_last_i (cnt_last),
    .rd_addr_i (cnt_q),
    .wr_i      (wr),
    .rd_o      (rd)
  );

  nnt_dist u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rd_i   (rd),
    .req_i  (req_q),
    .dist_o (dist_res)
  );

  // Sequencer: issue one slot read per cycle, let the distance pipeline
  // empty, then commit the table update and show the response.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        if (start_i) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cnt_d = cnt_q + IDX_W'(1);
        if (cnt_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (dist_res.last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // The match and free-slot searches watch the slots as they leave the
  // memory; the first hit is kept so the lowest slot wins.
  always_comb begin
    match_d     = match_q;
    match_idx_d = match_idx_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    have_d      = have_q;
    best_id_d   = best_id_q;
    best_d      = best_q;
    if (accept) begin
      match_d = 1'b0;
      free_d  = 1'b0;
      have_d  = 1'b0;
    end else begin
      if (rd.act && rd.vld && (rd.slot.id == req_q.entry_id) && !match_q) begin
        match_d     = 1'b1;
        match_idx_d = rd.idx;
      end
      if (rd.act && !rd.vld && !free_q) begin
        free_d     = 1'b1;
        free_idx_d = rd.idx;
      end
      // A later slot must be strictly nearer to replace the current best.
      if (dist_res.act && dist_res.cand && (!have_q || (dist_res.dsq < best_q))) begin
        have_d    = 1'b1;
        best_id_d = dist_res.id;
        best_d    = dist_res.dsq;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      match_q <= 1'b0;
      free_q  <= 1'b0;
      have_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      match_q <= match_d;
      free_q  <= free_d;
      have_q  <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    match_idx_q <= match_idx_d;
    free_idx_q  <= free_idx_d;
    best_id_q   <= best_id_d;
    best_q      <= best_d;
  end

  // Table update, committed in the response cycle.
  always_comb begin
    wr      = '0;
    wr.slot = '{id: req_q.entry_id, x: req_q.pos_x, y: req_q.pos_y, z: req_q.pos_z};
    if (state_q == S_DONE) begin
      if ((req_q.req_type == REQ_INSERT) && !match_q && free_q) begin
        wr.set  = 1'b1;
        wr.addr = free_idx_q;
      end else if ((req_q.req_type == REQ_REMOVE) && match_q) begin
        wr.clr  = 1'b1;
        wr.addr = match_idx_q;
      end
    end
  end

  // Response beat.
  always_comb begin
    rsp_o = '0;
    case (req_q.req_type)
      REQ_INSERT: begin
        if (!match_q && !free_q) begin
          rsp_o.status = ST_FULL;
        end
      end
      REQ_REMOVE: begin
        if (!match_q) begin
          rsp_o.status = ST_ABSENT;
        end
      end
      REQ_QUERY: begin
        if (have_q) begin
          rsp_o.found               = 1'b1;
          rsp_o.nearest_id          = best_id_q;
          rsp_o.nearest_distance_sq = best_q;
        end else begin
          rsp_o.status = ST_NONE;
        end
      end
      default: begin
        rsp_o = '0;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule

`default_nettype wire

// ===== rtl/nnt_checker.sv =====
// ----------------------------------------------------------------------------
// nnt_checker: port-level checks of the nearest neighbor table
// Watches the request and response ports and checks the beat timing and the
// consistency of response fields.
// ----------------------------------------------------------------------------
`default_nettype none

module nnt_port_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start_i,
  input logic          busy_i,
  input logic          done_i,
  input nnt_pkg::rsp_t rsp_i
);
  import nnt_pkg::*;

  // An accepted request makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_i |=> busy_i)
    else $error("accepted request did not raise busy");

  // The response beat lasts one cycle and ends the busy period.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |=> !done_i && !busy_i)
    else $error("response beat not followed by idle");

  // A response only appears while a request is being served.
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> busy_i)
    else $error("response beat outside a busy period");

  // A found point always comes with an ok status.
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i && rsp_i.found |-> rsp_i.status == ST_OK)
    else $error("found point with non-ok status");

  // Without a found point, identifier and distance are zero.
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i && !rsp_i.found |-> rsp_i.nearest_id == '0 && rsp_i.nearest_distance_sq == '0)
    else $error("nonzero nearest fields without a found point");

endmodule

bind nearest_neighbor_table nnt_port_checker u_nnt_port_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_i  (busy_o),
  .done_i  (done_o),
  .rsp_i   (rsp_o)
);

`default_nettype wire

// ===== tb/nnt_checker.sv =====
// ----------------------------------------------------------------------------
// nnt_checker: response checker for the nearest neighbor table
// Watches the request and response channels, keeps its own copy of the point
// table, predicts the response to every accepted request beat and compares
// each response beat, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module nnt_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          busy_i,
  input  nnt_pkg::req_t req_i,
  input  logic          done_i,
  input  nnt_pkg::rsp_t rsp_i,
  output int            error_count_o,
  output int            pending_o,
  output int            checked_o,
  output int            full_drops_o,
  output int            hits_o,
  output int            misses_o
);
  import nnt_pkg::*;

  // Shadow copy of the point table.
  logic                    pt_used [TABLE_DEPTH];
  logic [ID_W-1:0]         pt_id   [TABLE_DEPTH];
  logic signed [POS_W-1:0] pt_x    [TABLE_DEPTH];
  logic signed [POS_W-1:0] pt_y    [TABLE_DEPTH];
  logic signed [POS_W-1:0] pt_z    [TABLE_DEPTH];

  rsp_t expected_rsp_q [$];

  int n_errors  = 0;
  int n_pending = 0;
  int n_checked = 0;
  int n_full    = 0;
  int n_hits    = 0;
  int n_misses  = 0;

  assign error_count_o = n_errors;
  assign pending_o     = n_pending;
  assign checked_o     = n_checked;
  assign full_drops_o  = n_full;
  assign hits_o        = n_hits;
  assign misses_o      = n_misses;

  function automatic longint axis_sq(logic signed [POS_W-1:0] a,
                                     logic signed [POS_W-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return d * d;
  endfunction

  function automatic int slot_of_id(logic [ID_W-1:0] id);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (pt_used[i] && pt_id[i] == id) return i;
    end
    return -1;
  endfunction

  // Applies one request to the shadow table and returns the response it gives.
  function automatic rsp_t table_apply_request(req_t r);
    rsp_t   rsp;
    int     slot;
    logic   have;
    longint best;
    longint dsq;
    rsp  = '0;
    rsp.status = ST_OK;
    case (r.req_type)
      REQ_INSERT: begin
        if (slot_of_id(r.entry_id) < 0) begin
          slot = -1;
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (!pt_used[i]) begin
              slot = i;
              break;
            end
          end
          if (slot < 0) begin
            rsp.status = ST_FULL;
          end else begin
            pt_used[slot] = 1'b1;
            pt_id[slot]   = r.entry_id;
            pt_x[slot]    = r.pos_x;
            pt_y[slot]    = r.pos_y;
            pt_z[slot]    = r.pos_z;
          end
        end
      end
      REQ_REMOVE: begin
        slot = slot_of_id(r.entry_id);
        if (slot < 0) rsp.status = ST_ABSENT;
        else pt_used[slot] = 1'b0;
      end
      REQ_QUERY: begin
        have = 1'b0;
        best = 0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (!pt_used[i]) continue;
          if (r.exclude_enable && pt_id[i] == r.exclude_id) continue;
          dsq = axis_sq(pt_x[i], r.pos_x) + axis_sq(pt_y[i], r.pos_y)
              + axis_sq(pt_z[i], r.pos_z);
          // A later slot must be strictly nearer, so ties keep the lowest slot.
          if (!have || dsq < best) begin
            have = 1'b1;
            best = dsq;
            rsp.nearest_id = pt_id[i];
          end
        end
        if (have) begin
          rsp.found               = 1'b1;
          rsp.nearest_distance_sq = DSQ_W'(best);
        end else begin
          rsp.status = ST_NONE;
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      n_errors++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_DEPTH; i++) pt_used[i] = 1'b0;
      expected_rsp_q.delete();
      n_pending = 0;
    end else begin
      if (done_i) begin
        if (expected_rsp_q.size() == 0) begin
          n_errors++;
          $display("%0t: response beat with nothing expected: expected none, actual %p",
                   $time, rsp_i);
        end else begin
          want = expected_rsp_q.pop_front();
          check_field("status", want.status, rsp_i.status);
          check_field("found", want.found, rsp_i.found);
          check_field("nearest_id", want.nearest_id, rsp_i.nearest_id);
          check_field("nearest_distance_sq", want.nearest_distance_sq,
                      rsp_i.nearest_distance_sq);
          n_checked++;
          if (want.status == ST_FULL) n_full++;
          if (want.found) n_hits++;
          if (want.status == ST_NONE) n_misses++;
        end
      end
      if (start_i && !busy_i) expected_rsp_q.push_back(table_apply_request(req_i));
      n_pending = expected_rsp_q.size();
    end
  end

endmodule

// ===== tb/nearest_neighbor_table_test.sv =====
// ----------------------------------------------------------------------------
// nearest_neighbor_table_test: testbench top of the nearest neighbor table
// Drives a directed sequence and then about 1500 random request beats that
// fill, churn and drain the point table, and gives the verdict from the
// failure count of the response checker.
// ----------------------------------------------------------------------------
module nearest_neighbor_table_test;
  import nnt_pkg::*;

  // The package names no code for the unused request; it must still answer.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic signed [POS_W-1:0] POS_MIN = 16'sh8000;
  localparam logic signed [POS_W-1:0] POS_MAX = 16'sh7fff;
  localparam logic signed [POS_W-1:0] POS_ONE = 16'sh0100;

  localparam int NUM_RANDOM  = 1500;
  localparam int QUIET_TAIL  = 200;        // last beats are sent back to back
  localparam int BLOCK_LEN   = 150;        // beats per fill, churn or drain block
  localparam int ID_POOL     = 80;         // a bit more than the table holds
  localparam int TAIL_CYCLES = TABLE_DEPTH + 16;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  req_t req_i;
  logic busy_o;
  logic done_o;
  rsp_t rsp_o;

  int error_count;
  int pending;
  int checked;
  int full_drops;
  int hits;
  int misses;

  // Identifiers are mostly drawn from a small pool so that duplicate inserts,
  // removes of present points and exclusions of present points are common.
  logic [ID_W-1:0] id_pool [ID_POOL];

  nearest_neighbor_table i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  nnt_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_i       (busy_o),
    .req_i        (req_i),
    .done_i       (done_o),
    .rsp_i        (rsp_o),
    .error_count_o(error_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .full_drops_o (full_drops),
    .hits_o       (hits),
    .misses_o     (misses)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard limit on the run; the slowest correct run needs well under a fifth
  // of this.
  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic req_t make_request(logic [1:0] kind, logic [ID_W-1:0] id,
                                        logic signed [POS_W-1:0] x,
                                        logic signed [POS_W-1:0] y,
                                        logic signed [POS_W-1:0] z,
                                        logic excl, logic [ID_W-1:0] excl_id);
    req_t r;
    r.req_type       = kind;
    r.entry_id       = id;
    r.pos_x          = x;
    r.pos_y          = y;
    r.pos_z          = z;
    r.exclude_enable = excl;
    r.exclude_id     = excl_id;
    return r;
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(0, 99) < 85) return id_pool[$urandom_range(0, ID_POOL - 1)];
    return ID_W'($urandom);
  endfunction

  // Coordinates: often on a coarse grid so that equal distances (ties) are
  // frequent, sometimes at the range ends, otherwise anywhere.
  function automatic logic signed [POS_W-1:0] pick_coord();
    int g;
    g = $urandom_range(0, 4);
    case ($urandom_range(0, 9))
      0: return POS_MIN;
      1: return POS_MAX;
      2, 3, 4, 5: return POS_W'((g - 2) * 256);
      default: return POS_W'($urandom);
    endcase
  endfunction

  // The mix of requests follows the block: filling pushes the table to full,
  // churning keeps it half used and draining takes it down to a few points.
  function automatic req_t random_request(int mode);
    req_t r;
    int   roll;
    int   ins_pct;
    int   rem_pct;
    case (mode)
      0: begin ins_pct = 60; rem_pct = 10; end
      1: begin ins_pct = 35; rem_pct = 30; end
      default: begin ins_pct = 8; rem_pct = 62; end
    endcase
    roll = $urandom_range(0, 99);
    r = make_request(REQ_QUERY, pick_id(), pick_coord(), pick_coord(), pick_coord(),
                     1'($urandom), pick_id());
    if (roll < ins_pct) r.req_type = REQ_INSERT;
    else if (roll < ins_pct + rem_pct) r.req_type = REQ_REMOVE;
    else if (roll >= 97) r.req_type = REQ_UNUSED;
    return r;
  endfunction

  // Presents one request beat and returns at the edge that accepts it. busy_o
  // is read right after the edge, before the block updates it, so the value
  // seen is the one the edge sampled.
  task automatic send_beat(input req_t r);
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (busy_o);
  endtask

  // One idle burst of random length with start held low.
  task automatic idle_bursts();
    start_i <= 1'b0;
    repeat ($urandom_range(1, 13)) @(posedge clk_i);
  endtask

  initial begin
    start_i = 1'b0;
    req_i   = '0;
    rst_ni  = 1'b0;
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int i = 2; i < ID_POOL; i++) id_pool[i] = ID_W'($urandom);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. A query and a remove on the empty table come first.
    send_beat(make_request(REQ_QUERY, 16'h0000, 16'sh0, 16'sh0, 16'sh0, 1'b0, 16'h0));
    send_beat(make_request(REQ_REMOVE, 16'h00a5, 16'sh0, 16'sh0, 16'sh0, 1'b0, 16'h0));
    // Two points at opposite corners, then a duplicate of the first identifier
    // that must leave the table unchanged.
    send_beat(make_request(REQ_INSERT, 16'h0000, POS_MIN, POS_MIN, POS_MIN, 1'b0, 16'h0));
    send_beat(make_request(REQ_INSERT, 16'hffff, POS_MAX, POS_MAX, POS_MAX, 1'b0, 16'h0));
    send_beat(make_request(REQ_INSERT, 16'h0000, 16'sh0, 16'sh0, 16'sh0, 1'b0, 16'h0));
    send_beat(make_request(REQ_QUERY, 16'h0000, POS_MAX, POS_MAX, POS_MAX, 1'b0, 16'h0));
    // With the near corner excluded, the answer is the far corner at the
    // largest distance the coordinates allow.
    send_beat(make_request(REQ_QUERY, 16'h0000, POS_MIN, POS_MIN, POS_MIN, 1'b1, 16'h0000));
    send_beat(make_request(REQ_QUERY, 16'h0000, POS_MAX, POS_MAX, POS_MAX, 1'b1, 16'hffff));
    // Two points at the same distance from the origin: the lower slot wins.
    send_beat(make_request(REQ_INSERT, 16'h1234, 16'sh0, 16'sh0, 16'sh0, 1'b0, 16'h0));
    send_beat(make_request(REQ_INSERT, 16'h0005, POS_ONE, 16'sh0, 16'sh0, 1'b0, 16'h0));
    send_beat(make_request(REQ_INSERT, 16'h0006, -POS_ONE, 16'sh0, 16'sh0, 1'b0, 16'h0));
    send_beat(make_request(REQ_QUERY, 16'h0000, 16'sh0, 16'sh0, 16'sh0, 1'b1, 16'h1234));
    // The exclude identifier has no effect while exclusion is off.
    send_beat(make_request(REQ_QUERY, 16'h0000, 16'sh0, 16'sh0, 16'sh0, 1'b0, 16'h1234));
    // Remove, remove again, and refill the freed lowest slot.
    send_beat(make_request(REQ_REMOVE, 16'h0000, 16'sh0, 16'sh0, 16'sh0, 1'b0, 16'h0));
    send_beat(make_request(REQ_REMOVE, 16'h0000, 16'sh0, 16'sh0, 16'sh0, 1'b0, 16'h0));
    send_beat(make_request(REQ_INSERT, 16'h0007, 16'sh0, 16'sh0, 16'sh0200, 1'b0, 16'h0));
    send_beat(make_request(REQ_QUERY, 16'h0000, 16'sh0, 16'sh0, 16'sh0258, 1'b1, 16'h1234));
    // The unused request code with all fields set.
    send_beat(make_request(REQ_UNUSED, 16'hffff, POS_MAX, POS_MIN, POS_MAX, 1'b1, 16'hffff));

    // Random part, in blocks that fill, churn and drain the table in turn.
    for (int n = 0; n < NUM_RANDOM; n++) begin
      send_beat(random_request((n / BLOCK_LEN) % 3));
      if (n < NUM_RANDOM - QUIET_TAIL && $urandom_range(0, 3) == 0) idle_bursts();
    end
    start_i <= 1'b0;

    // Wait on the falling edge so that the checker has finished the rising one.
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("Checked %0d response beats: %0d queries found a point, %0d found none,",
             checked, hits, misses);
    $display("and %0d inserts were dropped on a full table.", full_drops);
    if (error_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/nnt_pkg.sv
rtl/nnt_store.sv
rtl/nnt_dist.sv
rtl/nearest_neighbor_table.sv
rtl/nnt_checker.sv
tb/nnt_checker.sv
tb/nearest_neighbor_table_test.sv
